// ----- rtl/core/scfla_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfla_pkg
// shared types, field widths and the size-to-class decode of the size class
// free list allocator
// ----------------------------------------------------------------------------
package scfla_pkg;

  localparam int SIZE_W   = 16;
  localparam int HANDLE_W = 11;
  localparam int CLASS_W  = 3;
  localparam int STATUS_W = 2;

  // class of an allocate before the range check, sizes up to 64 KiB give 0..13
  localparam int ACLS_W = 4;

  // sizes up to this many bytes fall in class 0
  localparam logic [SIZE_W-1:0] MIN_CLASS_BYTES = 16'd8;

  // fixed point shift of the reciprocal used to split a handle into class and index
  localparam int RECIP_SHIFT = 22;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_TOO_BIG   = 2'd1,
    STAT_BAD_FREE  = 2'd2,
    STAT_EXHAUSTED = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // floor(log2(size-1)) - 2, with small sizes in class 0
  function automatic logic [ACLS_W-1:0] class_of_size(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] v;
    logic [ACLS_W-1:0] lg;
    v  = size - 16'd1;
    lg = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (v[i]) begin
        lg = ACLS_W'(i);
      end
    end
    if (size <= MIN_CLASS_BYTES) begin
      return '0;
    end
    return lg - ACLS_W'(2);
  endfunction

endpackage

// ----- rtl/core/scfla_entry_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfla_entry_ram
// single port write, single port read entry memory with registered read data
// ----------------------------------------------------------------------------
module scfla_entry_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11,
  parameter int DW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/size_class_free_list_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_free_list_allocator
// segregated free list allocator: allocate pops a class list or hands out the
// next never-used entry, free checks the allocated mark and pushes back
// ----------------------------------------------------------------------------
// result: registered, loaded in S_EXEC once the result register is free
// interlock: a new word is taken only in S_IDLE, after the previous one is
//   done; the link/mark read is issued on accept, the update written in S_EXEC
// reset: all free lists empty, fill counts zero; no clearing pass, a mark is
//   only trusted below its class fill count, so the memory needs no init
// ----------------------------------------------------------------------------
module size_class_free_list_allocator
  import scfla_pkg::*;
#(
  parameter int NUM_CLASSES       = 8,
  parameter int ENTRIES_PER_CLASS = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                cmd_i,
  input  logic [SIZE_W-1:0]   alloc_size_i,
  input  logic [HANDLE_W-1:0] handle_in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [HANDLE_W-1:0] handle_out_o,
  output logic [CLASS_W-1:0]  size_class_o,
  output logic [STATUS_W-1:0] status_o
);

  localparam int Total = NUM_CLASSES * ENTRIES_PER_CLASS;
  localparam int IW    = $clog2(ENTRIES_PER_CLASS + 1);
  localparam int AW    = $clog2(Total);
  localparam int CIW   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int MW    = IW + 1;
  localparam int PW    = HANDLE_W + IW;
  localparam int QW    = HANDLE_W + RECIP_SHIFT;

  localparam logic [IW-1:0]          EpcIdx   = IW'(ENTRIES_PER_CLASS);
  localparam logic [AW-1:0]          EpcAddr  = AW'(ENTRIES_PER_CLASS);
  localparam logic [PW-1:0]          EpcWide  = PW'(ENTRIES_PER_CLASS);
  localparam logic [ACLS_W:0]        NumClsA  = (ACLS_W + 1)'(NUM_CLASSES);
  localparam logic [HANDLE_W-1:0]    NumClsH  = HANDLE_W'(NUM_CLASSES);
  localparam logic [RECIP_SHIFT-1:0] Recip    =
    RECIP_SHIFT'((64'd1 << RECIP_SHIFT) / ENTRIES_PER_CLASS);

  state_e state_q, state_d;

  logic [IW-1:0] head_q  [NUM_CLASSES];
  logic [IW-1:0] head_d  [NUM_CLASSES];
  logic [IW-1:0] fresh_q [NUM_CLASSES];
  logic [IW-1:0] fresh_d [NUM_CLASSES];

  // word taken in, decoded
  cmd_e                cmd_q;
  logic [ACLS_W-1:0]   a_cls_q;
  logic                a_big_q;
  logic [CIW-1:0]      a_ci_q;
  logic [AW-1:0]       a_base_q;
  logic [HANDLE_W-1:0] handle_q;
  logic [HANDLE_W-1:0] qest_q;

  // result register
  logic                out_valid_q, out_valid_d;
  logic [HANDLE_W-1:0] handle_out_q;
  logic [CLASS_W-1:0]  size_class_q;
  status_e             status_q;

  logic in_accept;
  logic out_free;

  // decode at accept
  logic [ACLS_W-1:0] a_cls_w;
  logic              a_big_w;
  logic [CIW-1:0]    a_ci_w;
  logic [AW-1:0]     a_base_w;
  logic [QW-1:0]     qprod_w;

  // entry memory
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [MW-1:0] ram_wdata, ram_rdata;
  logic          rd_mark;
  logic [IW-1:0] rd_link;

  // alloc resolve
  logic [IW-1:0] a_head;
  logic [IW-1:0] a_fresh;
  logic          a_pop;
  logic          a_new;
  logic [AW-1:0] a_addr;

  // free resolve
  logic [PW-1:0]       f_qprod;
  logic [PW-1:0]       f_rem0;
  logic                f_fix;
  logic [HANDLE_W-1:0] f_cls;
  logic [IW-1:0]       f_idx;
  logic                f_bad_cls;
  logic [CIW-1:0]      f_ci;
  logic                f_ok;

  // load enable and result going into the result register
  logic                res_load;
  logic [HANDLE_W-1:0] res_handle;
  logic [CLASS_W-1:0]  res_class;
  status_e             res_status;

  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;

  assign a_cls_w  = class_of_size(alloc_size_i);
  assign a_big_w  = {1'b0, a_cls_w} >= NumClsA;
  assign a_ci_w   = a_big_w ? '0 : a_cls_w[CIW-1:0];
  assign a_base_w = AW'(a_ci_w) * EpcAddr;
  // quotient estimate, at most one short of handle / entries per class
  assign qprod_w  = QW'(handle_in_i) * QW'(Recip);

  assign rd_mark = ram_rdata[MW-1];
  assign rd_link = ram_rdata[IW-1:0];

  assign a_head  = head_q[a_ci_q];
  assign a_fresh = fresh_q[a_ci_q];
  assign a_pop   = a_head < EpcIdx;
  assign a_new   = !a_pop && (a_fresh < EpcIdx);
  assign a_addr  = a_base_q + AW'(a_pop ? a_head : a_fresh);

  assign f_qprod   = PW'(qest_q) * EpcWide;
  assign f_rem0    = PW'(handle_q) - f_qprod;
  assign f_fix     = f_rem0 >= EpcWide;
  assign f_cls     = qest_q + HANDLE_W'(f_fix);
  assign f_idx     = IW'(f_fix ? (f_rem0 - EpcWide) : f_rem0);
  assign f_bad_cls = f_cls >= NumClsH;
  assign f_ci      = f_bad_cls ? '0 : f_cls[CIW-1:0];
  // entries at or past the fill count were never handed out, their mark is not trusted
  assign f_ok      = !f_bad_cls && rd_mark && (f_idx < fresh_q[f_ci]);

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    fresh_d    = fresh_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    res_load   = 1'b0;
    res_handle = '0;
    res_class  = '0;
    res_status = STAT_OK;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          ram_re    = 1'b1;
          ram_raddr = (cmd_e'(cmd_i) == CMD_FREE) ? AW'(handle_in_i)
                                                  : (a_base_w + AW'(head_q[a_ci_w]));
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        // read data stays put while the result register is full
        if (out_free) begin
          res_load = 1'b1;
          state_d  = S_IDLE;
          if (cmd_q == CMD_FREE) begin
            res_handle = handle_q;
            res_class  = f_cls[CLASS_W-1:0];
            if (f_ok) begin
              res_status   = STAT_OK;
              ram_we       = 1'b1;
              ram_waddr    = AW'(handle_q);
              ram_wdata    = {1'b0, head_q[f_ci]};
              head_d[f_ci] = f_idx;
            end else begin
              res_status = STAT_BAD_FREE;
            end
          end else if (a_big_q) begin
            res_status = STAT_TOO_BIG;
          end else if (a_pop || a_new) begin
            res_status = STAT_OK;
            res_handle = HANDLE_W'(a_addr);
            res_class  = a_cls_q[CLASS_W-1:0];
            ram_we     = 1'b1;
            ram_waddr  = a_addr;
            ram_wdata  = {1'b1, rd_link};
            if (a_pop) begin
              head_d[a_ci_q] = rd_link;
            end else begin
              fresh_d[a_ci_q] = a_fresh + IW'(1);
            end
          end else begin
            res_status = STAT_EXHAUSTED;
            res_class  = a_cls_q[CLASS_W-1:0];
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head_q[i]  <= EpcIdx;
        fresh_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      fresh_q     <= fresh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cmd_q    <= cmd_e'(cmd_i);
      a_cls_q  <= a_cls_w;
      a_big_q  <= a_big_w;
      a_ci_q   <= a_ci_w;
      a_base_q <= a_base_w;
      handle_q <= handle_in_i;
      qest_q   <= qprod_w[RECIP_SHIFT +: HANDLE_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      handle_out_q <= res_handle;
      size_class_q <= res_class;
      status_q     <= res_status;
    end
  end

  scfla_entry_ram #(
    .DEPTH (Total),
    .AW    (AW),
    .DW    (MW)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign handle_out_o = handle_out_q;
  assign size_class_o = size_class_q;
  assign status_o     = status_q;

  // the interlock keeps the next word out until the write-back is done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> in_stall_o)
    else $error("word taken while the previous one is still in flight");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("entry memory read and write in the same cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC) |-> (a_fresh <= EpcIdx))
    else $error("fill count past the class size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && (cmd_q == CMD_ALLOC) && a_pop && !a_big_q) |-> !rd_mark)
    else $error("popped entry is still marked allocated");

endmodule
